@@ rtl/core/akx_pkg.sv @@
`default_nettype none
package akx_pkg;

  localparam int unsigned WORD_W = 32;

  // Reduction polynomial term for xtime, and the round constant of round one
  localparam logic [7:0] RCON_POLY  = 8'h1b;
  localparam logic [7:0] RCON_FIRST = 8'h01;

  // Last round key index for each key size
  localparam logic [3:0] LAST_IDX_128 = 4'd10;
  localparam logic [3:0] LAST_IDX_256 = 4'd14;

  // S-box, entry 0 in the most significant byte
  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // Sequencer commands to the key window
  typedef struct packed {
    logic       load;    // take a new key into the window
    logic       step;    // emit the current round key and compute the next
    logic       is256;   // AES-256 schedule
    logic       rot;     // RotWord and round constant on this step
    logic [7:0] rcon;    // round constant of this step
  } seq_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [10:0] base;
    base = {~x, 3'b000};
    return SBOX_TBL[base +: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? RCON_POLY : 8'h00);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/akx_subword.sv @@
`default_nettype none
module akx_subword
  import akx_pkg::*;
(
  input  wire logic [WORD_W-1:0] word_in,
  output logic      [WORD_W-1:0] word_out
);

  // Four byte lookups in parallel
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      word_out[b*8 +: 8] = sbox(word_in[b*8 +: 8]);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/akx_datapath.sv @@
`default_nettype none
module akx_datapath
  import akx_pkg::*;
(
  input  wire logic        clk,
  input  wire seq_ctrl_t   ctrl,
  input  wire logic [63:0] key_word0,
  input  wire logic [63:0] key_word1,
  input  wire logic [63:0] key_word2,
  input  wire logic [63:0] key_word3,
  output logic      [63:0] round_key_hi,
  output logic      [63:0] round_key_lo
);

  // Words 0..3 are the round key on show, 4..7 the next one (AES-256 only)
  logic [WORD_W-1:0] w_r   [8];
  logic [WORD_W-1:0] w_nxt [8];
  logic [WORD_W-1:0] prev_word;
  logic [WORD_W-1:0] sub_in;
  logic [WORD_W-1:0] sub_out;
  logic [WORD_W-1:0] tmp_word;
  logic [WORD_W-1:0] new_w [4];

  akx_subword u_subword (
    .word_in  (sub_in),
    .word_out (sub_out)
  );

  always_comb begin
    prev_word = ctrl.is256 ? w_r[7] : w_r[3];
    sub_in    = ctrl.rot ? {prev_word[23:0], prev_word[31:24]} : prev_word;
    tmp_word  = sub_out ^ (ctrl.rot ? {ctrl.rcon, 24'h000000} : 32'h00000000);
    new_w[0]  = w_r[0] ^ tmp_word;
    new_w[1]  = w_r[1] ^ new_w[0];
    new_w[2]  = w_r[2] ^ new_w[1];
    new_w[3]  = w_r[3] ^ new_w[2];
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (ctrl.load) begin
      w_nxt[0] = key_word0[63:32];
      w_nxt[1] = key_word0[31:0];
      w_nxt[2] = key_word1[63:32];
      w_nxt[3] = key_word1[31:0];
      w_nxt[4] = key_word2[63:32];
      w_nxt[5] = key_word2[31:0];
      w_nxt[6] = key_word3[63:32];
      w_nxt[7] = key_word3[31:0];
    end else if (ctrl.step) begin
      if (ctrl.is256) begin
        for (int i = 0; i < 4; i++) begin
          w_nxt[i]     = w_r[i+4];
          w_nxt[i + 4] = new_w[i];
        end
      end else begin
        for (int i = 0; i < 4; i++) begin
          w_nxt[i] = new_w[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      w_r[i] <= w_nxt[i];
    end
  end

  assign round_key_hi = {w_r[0], w_r[1]};
  assign round_key_lo = {w_r[2], w_r[3]};

endmodule
`default_nettype wire

@@ rtl/core/akx_seq.sv @@
`default_nettype none
module akx_seq
  import akx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_key_is_256,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      round_index,
  output logic            last_key,
  output seq_ctrl_t       ctrl
);

  seq_state_t state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       is256_r, is256_nxt;
  logic       rot_r, rot_nxt;
  logic [7:0] rcon_r, rcon_nxt;
  logic       in_acc, out_acc, at_last;

  assign at_last = (idx_r == (is256_r ? LAST_IDX_256 : LAST_IDX_128));
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RUN;
      ST_RUN:  if (out_ready && at_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_RUN:  out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    is256_nxt = is256_r;
    rot_nxt   = rot_r;
    rcon_nxt  = rcon_r;
    if (in_acc) begin
      idx_nxt   = '0;
      is256_nxt = in_key_is_256;
      rot_nxt   = 1'b1;
      rcon_nxt  = RCON_FIRST;
    end else if (out_acc) begin
      idx_nxt  = idx_r + 4'd1;
      rot_nxt  = is256_r ? ~rot_r : 1'b1;
      rcon_nxt = rot_r ? xtime(rcon_r) : rcon_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      is256_r <= 1'b0;
      rot_r   <= 1'b1;
      rcon_r  <= RCON_FIRST;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      is256_r <= is256_nxt;
      rot_r   <= rot_nxt;
      rcon_r  <= rcon_nxt;
    end
  end

  assign round_index = idx_r;
  assign last_key    = at_last;

  always_comb begin
    ctrl.load  = in_acc;
    ctrl.step  = out_acc;
    ctrl.is256 = is256_r;
    ctrl.rot   = rot_r;
    ctrl.rcon  = rcon_r;
  end

endmodule
`default_nettype wire

@@ rtl/core/aes_key_expansion.sv @@
// A key is taken on the input handshake; round key 0 is shown on the next cycle.
// Throughput: one round key per cycle while out_ready is high; in_ready stays low
//   until the last round key of the item has been taken.
// The figure is set by the single shared SubWord unit: one round key per pass.
// Reset (rst_n low, synchronous): sequencer idle, round counter zero, no item held.
`default_nettype none
module aes_key_expansion
  import akx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_key_word0,
  input  wire logic [63:0] in_key_word1,
  input  wire logic [63:0] in_key_word2,
  input  wire logic [63:0] in_key_word3,
  input  wire logic        in_key_is_256,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_round_index,
  output logic [63:0]      out_round_key_hi,
  output logic [63:0]      out_round_key_lo,
  output logic             out_last_key
);

  seq_ctrl_t ctrl;

  // Sequencer: accept a key, then walk the round keys one per handshake.
  // The round constant advances only on steps that apply RotWord; for AES-256
  // these alternate with plain SubWord steps.
  akx_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_key_is_256 (in_key_is_256),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .round_index   (out_round_index),
    .last_key      (out_last_key),
    .ctrl          (ctrl)
  );

  // Key window: holds the round key on show plus, for AES-256, the next one.
  // Each step emits words 0..3 and derives four new words through the shared
  // SubWord unit and a short XOR chain.
  akx_datapath u_datapath (
    .clk          (clk),
    .ctrl         (ctrl),
    .key_word0    (in_key_word0),
    .key_word1    (in_key_word1),
    .key_word2    (in_key_word2),
    .key_word3    (in_key_word3),
    .round_key_hi (out_round_key_hi),
    .round_key_lo (out_round_key_lo)
  );

endmodule
`default_nettype wire
